FILE: rtl/core/stns_pkg.sv
// Shared types and constants for the same-type neighbor search block.
`default_nettype none
package stns_pkg;
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_NEAREST = 2'd1;
    localparam logic [1:0] KIND_SEP     = 2'd2;

    // Far limit 2000.0 in Q12.4, squared
    localparam logic [33:0] FAR_LIMIT_SQ = 34'd1024000000;

    // Result item
    typedef struct packed {
        logic [16:0] sep_y;
        logic [16:0] sep_x;
        logic [8:0]  neighbor_count;
        logic [7:0]  nearest_index;
        logic        found;
    } result_t;
endpackage
`default_nettype wire

FILE: rtl/core/same_type_neighbor_search_top.sv
// Top level of the same-type neighbor search block.
// A load request is written in the cycle it is accepted, so loads can follow back to back.
// A query reads one stored point per cycle through the point RAM's single read port. It scans the
// first n points, where n is points_in_use limited to MAX_POINTS (none when a separation query's
// own index is out of range). When a separation query has neighbors, its two averages then run
// one after the other through a 24-step serial divider. The block takes no new request while a
// query runs. A finished result sits in an output register, and only the next query's result
// waits for it to be taken.
`default_nettype none
module same_type_neighbor_search_top #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // index[7:0], pos_x[23:8], pos_y[39:24], radius[54:40], point_type[62:55], pad
    input  wire logic [63:0] s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found[0], nearest_index[8:1], neighbor_count[17:9], sep_x[34:18], sep_y[51:35]
    output logic [55:0]      m_tdata
);
    import stns_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SELF = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [8:0] piu_reg;
    logic [2:0] state_reg;
    logic [1:0] kind_reg;
    logic [7:0] self_reg;
    logic signed [15:0] qx_reg, qy_reg;
    logic [15:0] rad_reg;
    logic [7:0] qt_reg;
    logic [CW-1:0] lim_reg;
    logic [CW-1:0] addr_reg;      // address being read
    logic [CW-1:0] idx_reg;       // address of data now at RAM output
    logic       rv_reg;           // RAM output holds a scan entry
    logic       hit_reg;
    logic [7:0] at_reg;
    logic [33:0] best_reg;
    logic signed [24:0] sx_reg, sy_reg;
    logic [8:0] cnt_reg;
    logic       divy_reg;
    logic [16:0] qxr_reg;
    result_t    res_reg;
    logic       ov_reg;

    logic [7:0] pindex;
    logic [15:0] ppx, ppy;
    logic [14:0] prad;
    logic [7:0] ptype;
    assign pindex = s_tdata[7:0];
    assign ppx    = s_tdata[23:8];
    assign ppy    = s_tdata[39:24];
    assign prad   = s_tdata[54:40];
    assign ptype  = s_tdata[62:55];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // result register loads once the previous result is gone or leaving
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || m_tready);

    // point RAM: one port, write on load, reads for the self entry and the scan
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [39:0] ram_wdata, ram_rdata;
    assign ram_we    = accept && (s_tuser == KIND_LOAD) && (int'(pindex) < MAX_POINTS);
    assign ram_wdata = {ptype, ppy, ppx};
    always_comb
    begin
        if (state_reg == ST_IDLE)
            ram_addr = AW'(pindex);
        else
            ram_addr = addr_reg[AW-1:0];
    end

    stns_ram #(.WIDTH(40), .DEPTH(MAX_POINTS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    // shared distance unit for the entry at the RAM output
    logic signed [16:0] dx, dy;
    logic signed [33:0] dxx, dyy;
    logic [33:0] dsq;
    logic [31:0] win;
    logic        same, notself, inwin;
    assign dx      = 17'(qx_reg) - 17'($signed(ram_rdata[15:0]));
    assign dy      = 17'(qy_reg) - 17'($signed(ram_rdata[31:16]));
    assign dxx     = dx * dx;
    assign dyy     = dy * dy;
    assign dsq     = $unsigned(dxx) + $unsigned(dyy);
    assign win     = rad_reg * rad_reg;
    assign same    = ram_rdata[39:32] == qt_reg;
    assign notself = int'(idx_reg) != int'(self_reg);
    assign inwin   = dsq < {2'b0, win};

    // divider shared by both axes
    logic        div_start, div_done;
    logic signed [24:0] div_num;
    logic [16:0] div_q;
    assign div_num = divy_reg ? -sy_reg : -sx_reg;
    stns_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_num),
        .divisor(cnt_reg), .done(div_done), .quotient(div_q)
    );
    assign div_start = (state_reg == ST_DIV) && !rv_reg;

    logic [CW-1:0] lim_c;
    assign lim_c = (int'(piu_reg) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(piu_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg   <= '0;
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            divy_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                piu_reg <= cfg_wdata;
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (s_tuser == KIND_NEAREST || s_tuser == KIND_SEP))
                    begin
                        kind_reg <= s_tuser;
                        self_reg <= pindex;
                        qx_reg   <= $signed(ppx);
                        qy_reg   <= $signed(ppy);
                        rad_reg  <= {prad, 1'b0};
                        qt_reg   <= ptype;
                        lim_reg  <= lim_c;
                        hit_reg  <= 1'b0;
                        at_reg   <= '0;
                        best_reg <= FAR_LIMIT_SQ;
                        sx_reg   <= '0;
                        sy_reg   <= '0;
                        cnt_reg  <= '0;
                        addr_reg <= '0;
                        rv_reg   <= 1'b0;
                        if (s_tuser == KIND_SEP)
                            state_reg <= ST_SELF;
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SELF:
                begin
                    // RAM output now holds the self entry
                    qx_reg <= $signed(ram_rdata[15:0]);
                    qy_reg <= $signed(ram_rdata[31:16]);
                    qt_reg <= ram_rdata[39:32];
                    if (int'(self_reg) >= MAX_POINTS)
                        lim_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // evaluate entry fetched last cycle
                    if (rv_reg && same && notself && inwin)
                    begin
                        if (kind_reg == KIND_NEAREST)
                        begin
                            if (dsq < best_reg)
                            begin
                                best_reg <= dsq;
                                at_reg   <= 8'(idx_reg);
                                hit_reg  <= 1'b1;
                            end
                        end
                        else
                        begin
                            sx_reg  <= sx_reg + 25'(dx);
                            sy_reg  <= sy_reg + 25'(dy);
                            cnt_reg <= cnt_reg + 9'd1;
                        end
                    end
                    idx_reg <= addr_reg;
                    if (addr_reg < lim_reg)
                    begin
                        rv_reg   <= 1'b1;
                        addr_reg <= addr_reg + CW'(1);
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                        if (!rv_reg)
                        begin
                            if (kind_reg == KIND_SEP && cnt_reg != 9'd0)
                            begin
                                divy_reg  <= 1'b0;
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                state_reg <= ST_OUT;
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    // rv_reg marks a divide in flight
                    rv_reg <= !div_done;
                    if (div_done)
                    begin
                        if (!divy_reg)
                        begin
                            qxr_reg  <= div_q;
                            divy_reg <= 1'b1;
                        end
                        else
                        begin
                            divy_reg  <= 1'b0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        res_reg.found <= (kind_reg == KIND_NEAREST) ? hit_reg : 1'b0;
                        res_reg.nearest_index <= (kind_reg == KIND_NEAREST) ? at_reg : 8'd0;
                        res_reg.neighbor_count <= (kind_reg == KIND_SEP) ? cnt_reg : 9'd0;
                        res_reg.sep_x <= (cnt_reg != 9'd0 && kind_reg == KIND_SEP)
                                         ? qxr_reg : 17'd0;
                        res_reg.sep_y <= (cnt_reg != 9'd0 && kind_reg == KIND_SEP)
                                         ? div_q : 17'd0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'd0, res_reg};
endmodule
`default_nettype wire

FILE: rtl/core/stns_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module stns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/stns_div.sv
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
`default_nettype none
module stns_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic signed [24:0] dividend,
    input  wire logic [8:0]  divisor,
    output logic             done,
    output logic [16:0]      quotient
);
    logic [23:0] rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [8:0]  den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;
    logic [23:0] mag;
    logic [23:0] qsign;

    assign mag   = dividend[24] ? 24'(-dividend) : dividend[23:0];
    assign trial = {rem_reg, quo_reg[23]} - {16'd0, den_reg};
    assign qsign = neg_reg ? -quo_reg : quo_reg;

    // shift-subtract step
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            den_next  = divisor;
            neg_next  = dividend[24];
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[24])
            begin
                rem_next = trial[23:0];
                quo_next = {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[22:0], quo_reg[23]};
                quo_next = {quo_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = qsign[16:0];
endmodule
`default_nettype wire

FILE: rtl/core/stns_checker.sv
// Port-level checker for the neighbor search top level, with its bind.
`default_nettype none
module stns_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // a result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a request stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("request dropped while stalled");

    // a result never carries both a hit and a count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[17:9] != 9'd0))
        else $error("mixed result kinds");

    // zero count means zero separation
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17:9] == 9'd0 |-> m_tdata[51:18] == 34'd0)
        else $error("separation without neighbors");
endmodule

bind same_type_neighbor_search_top stns_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
